// File: sv/tea_pkg.sv
package tea_pkg;

  localparam logic [31:0] TeaDelta = 32'h9E3779B9;

  // key register indexes on the write port
  localparam logic [1:0] KeyIdx0 = 2'd0;
  localparam logic [1:0] KeyIdx1 = 2'd1;
  localparam logic [1:0] KeyIdx2 = 2'd2;
  localparam logic [1:0] KeyIdx3 = 2'd3;

  // mode bit carried with each beat
  localparam logic FuncEncrypt = 1'b0;
  localparam logic FuncDecrypt = 1'b1;

  typedef struct packed {
    logic [31:0] k0;
    logic [31:0] k1;
    logic [31:0] k2;
    logic [31:0] k3;
  } tea_key_t;

  function automatic logic [31:0] tea_mix(logic [31:0] x, logic [31:0] sum,
                                          logic [31:0] ka, logic [31:0] kb);
    tea_mix = ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
  endfunction

endpackage

// File: sv/tea_key_regs.sv
module tea_key_regs
  import tea_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  output tea_key_t    key_o
);

  tea_key_t key_q, key_d;

  always_comb begin
    key_d = key_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        KeyIdx0: key_d.k0 = cfg_wdata_i;
        KeyIdx1: key_d.k1 = cfg_wdata_i;
        KeyIdx2: key_d.k2 = cfg_wdata_i;
        KeyIdx3: key_d.k3 = cfg_wdata_i;
        default: key_d = key_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else begin
      key_q <= key_d;
    end
  end

  assign key_o = key_q;

endmodule

// File: sv/tea_half_round.sv
module tea_half_round
  import tea_pkg::*;
#(
  parameter logic [31:0] SumEnc = 32'h9E3779B9,
  parameter logic [31:0] SumDec = 32'h9E3779B9,
  parameter bit          Half   = 1'b0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  tea_key_t    key_i,
  input  logic        valid_i,
  input  logic        func_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        valid_o,
  output logic        func_o,
  output logic [31:0] a_o,
  output logic [31:0] b_o
);

  logic        valid_q;
  logic        func_q;
  logic [31:0] a_q, a_d;
  logic [31:0] b_q, b_d;
  logic        upd_a;
  logic [31:0] x, sum, ka, kb, m, tgt, res;

  // encrypt touches a on the first half, decrypt touches b first
  assign upd_a = (func_i == FuncEncrypt) ^ Half;
  assign x     = upd_a ? b_i : a_i;
  assign tgt   = upd_a ? a_i : b_i;
  assign ka    = upd_a ? key_i.k0 : key_i.k2;
  assign kb    = upd_a ? key_i.k1 : key_i.k3;
  assign sum   = (func_i == FuncDecrypt) ? SumDec : SumEnc;
  assign m     = tea_mix(x, sum, ka, kb);
  assign res   = (func_i == FuncDecrypt) ? (tgt - m) : (tgt + m);

  always_comb begin
    a_d = a_i;
    b_d = b_i;
    if (upd_a) begin
      a_d = res;
    end else begin
      b_d = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_i;
    a_q    <= a_d;
    b_q    <= b_d;
  end

  assign valid_o = valid_q;
  assign func_o  = func_q;
  assign a_o     = a_q;
  assign b_o     = b_q;

endmodule

// File: sv/tea_block_cipher_unit.sv
// an accepted block reaches done_o once it has passed every half-round register stage
// throughput: one block per cycle, one register stage per half-round
// busy_o is held low, a start beat is taken on every cycle
// reset clears the key words to zero and empties the pipeline
// done_o pulses one cycle per block, the receiver cannot stall
module tea_block_cipher_unit
  import tea_pkg::*;
#(
  parameter int ROUNDS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        func_i,
  input  logic [31:0] block_low_i,
  input  logic [31:0] block_high_i,
  output logic        done_o,
  output logic [31:0] out_low_o,
  output logic [31:0] out_high_o
);

  localparam int NumStages = 2 * ROUNDS;

  tea_key_t    key;
  logic        valid [NumStages+1];
  logic        func  [NumStages+1];
  logic [31:0] a_w   [NumStages+1];
  logic [31:0] b_w   [NumStages+1];

  tea_key_regs u_keys (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .key_o       (key)
  );

  assign busy_o   = 1'b0;
  assign valid[0] = start_i && !busy_o;
  assign func[0]  = func_i;
  assign a_w[0]   = block_low_i;
  assign b_w[0]   = block_high_i;

  for (genvar g = 0; g < NumStages; g++) begin : g_stage
    localparam logic [63:0] EncW = 64'(TeaDelta) * 64'(g / 2 + 1);
    localparam logic [63:0] DecW = 64'(TeaDelta) * 64'(ROUNDS - g / 2);

    tea_half_round #(
      .SumEnc (EncW[31:0]),
      .SumDec (DecW[31:0]),
      .Half   (bit'(g % 2))
    ) u_half (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .key_i   (key),
      .valid_i (valid[g]),
      .func_i  (func[g]),
      .a_i     (a_w[g]),
      .b_i     (b_w[g]),
      .valid_o (valid[g+1]),
      .func_o  (func[g+1]),
      .a_o     (a_w[g+1]),
      .b_o     (b_w[g+1])
    );
  end

  assign done_o     = valid[NumStages];
  assign out_low_o  = a_w[NumStages];
  assign out_high_o = b_w[NumStages];

`ifndef SYNTH
  // every accepted beat comes out once it has passed through the whole pipeline
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##(NumStages) done_o)
    else $error("accepted block did not complete on time");

  // no result without a matching accepted beat
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, NumStages))
    else $error("result without an accepted block");
`endif

endmodule

// File: tb/tea_block_cipher_unit_tb.sv
`timescale 1ns / 1ps

module tea_block_cipher_unit_tb;
  import tea_pkg::*;

  localparam int TeaRounds = 32;
  localparam int PhaseBlocks = 125;
  localparam int NumPhases = 6;
  localparam int StallLimit = 4096;

  // expected cipher outputs, predicted when a start beat is taken
  class tea_block_board;
    logic [63:0] expected_blocks[$];
    logic [31:0] key_word[4];
    logic [31:0] last_low, last_high;
    int errors, checked, n_encrypt, n_decrypt;

    function new();
      foreach (key_word[i]) key_word[i] = '0;
      errors = 0;
      checked = 0;
      n_encrypt = 0;
      n_decrypt = 0;
      last_low = '0;
      last_high = '0;
    endfunction

    function void set_key(int idx, logic [31:0] value);
      key_word[idx] = value;
    endfunction

    function logic [31:0] half_round(logic [31:0] x, logic [31:0] sum,
                                     logic [31:0] ka, logic [31:0] kb);
      logic [31:0] shl, shr;
      shl = {x[27:0], 4'b0};
      shr = {5'b0, x[31:5]};
      return (shl + ka) ^ (x + sum) ^ (shr + kb);
    endfunction

    function void note_block(logic func, logic [31:0] lo, logic [31:0] hi);
      logic [31:0] a, b, sum;
      a = lo;
      b = hi;
      if (func == FuncEncrypt) begin
        sum = '0;
        for (int r = 0; r < TeaRounds; r++) begin
          sum = sum + TeaDelta;
          a = a + half_round(b, sum, key_word[0], key_word[1]);
          b = b + half_round(a, sum, key_word[2], key_word[3]);
        end
        n_encrypt++;
        last_low = a;
        last_high = b;
      end else begin
        sum = TeaDelta * TeaRounds;
        for (int r = 0; r < TeaRounds; r++) begin
          b = b - half_round(a, sum, key_word[2], key_word[3]);
          a = a - half_round(b, sum, key_word[0], key_word[1]);
          sum = sum - TeaDelta;
        end
        n_decrypt++;
      end
      expected_blocks.push_back({b, a});
    endfunction

    function void check_block(logic [31:0] lo, logic [31:0] hi);
      logic [63:0] exp_block;
      if (expected_blocks.size() == 0) begin
        $display("%0t: result beat with nothing expected, got %h %h", $time, lo, hi);
        errors++;
        return;
      end
      exp_block = expected_blocks.pop_front();
      checked++;
      if (lo !== exp_block[31:0]) begin
        $display("%0t: out_low expected %h, got %h", $time, exp_block[31:0], lo);
        errors++;
      end
      if (hi !== exp_block[63:32]) begin
        $display("%0t: out_high expected %h, got %h", $time, exp_block[63:32], hi);
        errors++;
      end
    endfunction

    function int pending();
      return expected_blocks.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;
  logic        start_i;
  logic        busy_o;
  logic        func_i;
  logic [31:0] block_low_i;
  logic [31:0] block_high_i;
  logic        done_o;
  logic [31:0] out_low_o;
  logic [31:0] out_high_o;

  tea_block_board board;
  int stall_cycles;

  tea_block_cipher_unit #(
    .ROUNDS(TeaRounds)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .func_i      (func_i),
    .block_low_i (block_low_i),
    .block_high_i(block_high_i),
    .done_o      (done_o),
    .out_low_o   (out_low_o),
    .out_high_o  (out_high_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      board.check_block(out_low_o, out_high_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o || cfg_we_i) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("%0t: no progress for %0d cycles", $time, StallLimit);
        $display("tea_block_cipher_unit test failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic send_block(logic func, logic [31:0] lo, logic [31:0] hi);
    start_i      <= 1'b1;
    func_i       <= func;
    block_low_i  <= lo;
    block_high_i <= hi;
    do @(posedge clk_i); while (busy_o);
    board.note_block(func, lo, hi);
  endtask

  task automatic idle_sender(int cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // keys change only with the pipeline empty
  task automatic load_keys(logic [31:0] k0, logic [31:0] k1,
                           logic [31:0] k2, logic [31:0] k3);
    logic [31:0] words[4];
    logic [1:0]  idx[4];
    words = '{k0, k1, k2, k3};
    idx = '{KeyIdx0, KeyIdx1, KeyIdx2, KeyIdx3};
    start_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx[i];
      cfg_wdata_i <= words[i];
      @(posedge clk_i);
      board.set_key(i, words[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h1 << $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  initial begin
    logic [31:0] dir_words[7][2];
    logic [31:0] k[4];
    logic        func;
    logic [31:0] lo, hi;
    bit          quiet;

    board = new();
    stall_cycles = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = KeyIdx0;
    cfg_wdata_i = '0;
    start_i = 1'b0;
    func_i = FuncEncrypt;
    block_low_i = '0;
    block_high_i = '0;
    dir_words = '{'{32'h0000_0000, 32'h0000_0000}, '{32'hFFFF_FFFF, 32'hFFFF_FFFF},
                  '{32'h0000_0000, 32'hFFFF_FFFF}, '{32'hFFFF_FFFF, 32'h0000_0000},
                  '{32'hAAAA_AAAA, 32'h5555_5555}, '{32'h8000_0000, 32'h0000_0001},
                  '{32'h0000_0001, 32'h8000_0000}};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset keys are all zero: extremes both ways, back to back
    foreach (dir_words[i]) begin
      send_block(FuncEncrypt, dir_words[i][0], dir_words[i][1]);
      send_block(FuncDecrypt, dir_words[i][0], dir_words[i][1]);
    end
    // known zero-key ciphertext of the zero block
    send_block(FuncDecrypt, 32'h41EA_3A0A, 32'h94BA_A940);

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: k = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        1: k = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
        2: k = '{32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'hFFFF_FFFE};
        default: k = '{pick_word(), pick_word(), pick_word(), pick_word()};
      endcase
      load_keys(k[0], k[1], k[2], k[3]);
      quiet = (ph == NumPhases - 1);
      for (int n = 0; n < PhaseBlocks; n++) begin
        // sometimes decrypt the newest ciphertext to close the loop
        if (board.n_encrypt > 0 && $urandom_range(0, 7) == 0) begin
          func = FuncDecrypt;
          lo = board.last_low;
          hi = board.last_high;
        end else begin
          func = $urandom_range(0, 1) ? FuncDecrypt : FuncEncrypt;
          lo = pick_word();
          hi = pick_word();
        end
        send_block(func, lo, hi);
        if (!quiet && $urandom_range(0, 3) == 0) begin
          idle_sender($urandom_range(1, 9));
        end
      end
    end

    start_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (2 * TeaRounds + 8) @(posedge clk_i);

    $display("%0d encrypt and %0d decrypt beats over %0d key settings, %0d results checked",
             board.n_encrypt, board.n_decrypt, NumPhases + 1, board.checked);
    if (board.errors == 0) begin
      $display("tea_block_cipher_unit test passed");
    end else begin
      $display("%0d mismatches", board.errors);
      $display("tea_block_cipher_unit test failed");
    end
    $finish;
  end

endmodule

// File: files.f
sv/tea_pkg.sv
sv/tea_key_regs.sv
sv/tea_half_round.sv
sv/tea_block_cipher_unit.sv
tb/tea_block_cipher_unit_tb.sv
